// ===== rtl/bsaf_pkg.sv =====
package bsaf_pkg;

  // Command codes carried in the slave-side tuser
  typedef enum logic [1:0] {
    CMD_START_CMD = 2'd0,
    CMD_START_ARG = 2'd1,
    CMD_DATA      = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_CONV,
    ST_SKIP,
    ST_DIGIT,
    ST_CR,
    ST_LF,
    ST_DATA,
    ST_ERR
  } state_t;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam int CMD_W  = 2;
  localparam int COUNT_W = 16;
  localparam int LEN_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int IN_DATA_W = 56;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } beat_t;

  typedef struct packed {
    logic start;
    logic shift_digit;
  } conv_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] top_digit;
    logic       last_digit;
  } conv_stat_t;

endpackage

// ===== rtl/bsaf_bcd.sv =====
module bsaf_bcd import bsaf_pkg::*; #(
  parameter int VAL_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  conv_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] value,
  output conv_stat_t       stat
);

  // decimal digits of 2^VAL_W - 1
  localparam int DIG_N  = (VAL_W * 301) / 1000 + 1;
  localparam int BCD_W  = DIG_N * 4;
  localparam int BIT_CW = $clog2(VAL_W + 1);
  localparam int DIG_CW = $clog2(DIG_N + 1);

  logic [VAL_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [BIT_CW-1:0] bit_cnt;
  logic [DIG_CW-1:0] dig_left;

  // double dabble: bump every nibble >= 5 before the shift
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt  <= '0;
      dig_left <= '0;
    end else if (ctrl.start) begin
      bit_cnt  <= BIT_CW'(VAL_W);
      dig_left <= DIG_CW'(DIG_N);
    end else if (bit_cnt != '0) begin
      bit_cnt <= bit_cnt - BIT_CW'(1);
    end else if (ctrl.shift_digit) begin
      dig_left <= dig_left - DIG_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin <= value;
      bcd <= '0;
    end else if (bit_cnt != '0) begin
      bin <= {bin[VAL_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VAL_W-1]};
    end else if (ctrl.shift_digit) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
  end

  assign stat.done       = (bit_cnt == '0);
  assign stat.top_digit  = bcd[BCD_W-1 -: 4];
  assign stat.last_digit = (dig_left == DIG_CW'(1));

endmodule

// ===== rtl/bsaf_obuf.sv =====
module bsaf_obuf import bsaf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  beat_t      beat,
  output logic       out_free,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic       m_tuser
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      m_tdata <= beat.out_byte;
      m_tlast <= beat.last;
      m_tuser <= beat.error;
    end
  end

endmodule

// ===== rtl/bulk_string_array_framer_core.sv =====
// Channel  Dir  Signals                      Content
// s_*      in   tvalid tready tdata tuser    one request item per beat
// m_*      out  tvalid tready tdata tlast    one framed byte per beat, tuser = error
//
// Steps: data item: accept, then the byte (and CR LF when it ends the argument);
// count or length item: accept, prefix, the bit-serial binary-to-BCD converter
// (one bit a cycle), the digit walk (one digit a cycle while out_free), then
// CR LF (twice for an empty argument). Error item: accept, then the error beat.
// Reset clears counters, FSM and the output register's valid bit.
// A stalled master side holds the FSM in its emitting state; s_tready is high
// only in idle, the output register lets a new item in while a beat waits.
module bulk_string_array_framer_core import bsaf_pkg::*; #(
  parameter int LENGTH_BITS = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [15:0] arg_count, [47:16] arg_length, [55:48] data_byte
  input  logic [IN_DATA_W-1:0] s_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]     s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [7:0] out_byte
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  // [0] error
  output logic                 m_tuser
);

  localparam int VAL_W = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;

  state_t state, state_next;

  logic [COUNT_BITS-1:0]  args_rem;
  logic [LENGTH_BITS-1:0] bytes_rem;
  logic                   tail;       // CR LF still owed after the current one
  logic [7:0]             pfx;
  logic [7:0]             data_reg;

  cmd_t           cmd;
  logic [COUNT_W-1:0] in_count;
  logic [LEN_W-1:0]   in_len;
  logic [BYTE_W-1:0]  in_byte;
  logic [47:0]        count_ext;
  logic [47:0]        len_ext;
  logic               accept;
  logic               ok;
  logic               count_wide;
  logic               len_wide;

  conv_ctrl_t conv_ctrl;
  conv_stat_t conv_stat;
  logic       emit;
  beat_t      beat;
  logic       out_free;

  assign cmd       = cmd_t'(s_tuser);
  assign in_count  = s_tdata[15:0];
  assign in_len    = s_tdata[47:16];
  assign in_byte   = s_tdata[55:48];
  assign count_ext = {32'd0, in_count};
  assign len_ext   = {16'd0, in_len};
  assign count_wide = (in_count >> COUNT_BITS) != '0;
  assign len_wide   = (in_len >> LENGTH_BITS) != '0;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // order checks against the stored counters, plus range checks on the incoming count and length
  always_comb begin
    case (cmd)
      CMD_START_CMD: ok = (args_rem == '0) && (bytes_rem == '0) && !count_wide;
      CMD_START_ARG: ok = (args_rem != '0) && (bytes_rem == '0) && !len_wide;
      CMD_DATA:      ok = (bytes_rem != '0);
      default:       ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!ok) begin
            state_next = ST_ERR;
          end else if (cmd == CMD_DATA) begin
            state_next = ST_DATA;
          end else begin
            state_next = ST_PREFIX;
          end
        end
      end
      ST_PREFIX: if (out_free) state_next = ST_CONV;
      ST_CONV:   if (conv_stat.done) state_next = ST_SKIP;
      ST_SKIP: begin
        if (conv_stat.top_digit != 4'd0 || conv_stat.last_digit) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: if (out_free && conv_stat.last_digit) state_next = ST_CR;
      ST_CR:    if (out_free) state_next = ST_LF;
      ST_LF, ST_DATA: begin
        if (out_free) begin
          state_next = tail ? ST_CR : ST_IDLE;
        end
      end
      ST_ERR:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit = 1'b0;
    beat = '{out_byte: 8'd0, last: 1'b0, error: 1'b0};
    conv_ctrl.start       = 1'b0;
    conv_ctrl.shift_digit = 1'b0;
    case (state)
      ST_IDLE: begin
        conv_ctrl.start = accept && ok && (cmd != CMD_DATA);
      end
      ST_PREFIX: begin
        emit = 1'b1;
        beat.out_byte = pfx;
      end
      ST_SKIP: begin
        conv_ctrl.shift_digit = (conv_stat.top_digit == 4'd0) && !conv_stat.last_digit;
      end
      ST_DIGIT: begin
        emit = 1'b1;
        beat.out_byte = CH_ZERO + {4'd0, conv_stat.top_digit};
        conv_ctrl.shift_digit = out_free && !conv_stat.last_digit;
      end
      ST_CR: begin
        emit = 1'b1;
        beat.out_byte = CH_CR;
      end
      ST_LF: begin
        emit = 1'b1;
        beat.out_byte = CH_LF;
        beat.last = !tail;
      end
      ST_DATA: begin
        emit = 1'b1;
        beat.out_byte = data_reg;
        beat.last = !tail;
      end
      ST_ERR: begin
        emit = 1'b1;
        beat.last  = 1'b1;
        beat.error = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      args_rem  <= '0;
      bytes_rem <= '0;
      tail      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && ok) begin
        case (cmd)
          CMD_START_CMD: begin
            args_rem <= count_ext[COUNT_BITS-1:0];
            tail     <= 1'b0;
          end
          CMD_START_ARG: begin
            args_rem  <= args_rem - COUNT_BITS'(1);
            bytes_rem <= len_ext[LENGTH_BITS-1:0];
            tail      <= (in_len == '0);
          end
          CMD_DATA: begin
            bytes_rem <= bytes_rem - LENGTH_BITS'(1);
            tail      <= (bytes_rem == LENGTH_BITS'(1));
          end
          default: begin
            tail <= tail;
          end
        endcase
      end else if ((state == ST_LF || state == ST_DATA) && out_free && tail) begin
        tail <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pfx      <= (cmd == CMD_START_CMD) ? CH_STAR : CH_DOLLAR;
      data_reg <= in_byte;
    end
  end

  logic [VAL_W-1:0] conv_value;
  assign conv_value = (cmd == CMD_START_CMD) ? count_ext[VAL_W-1:0] : len_ext[VAL_W-1:0];

  bsaf_bcd #(
    .VAL_W (VAL_W)
  ) u_bcd (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (conv_ctrl),
    .value (conv_value),
    .stat  (conv_stat)
  );

  bsaf_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (emit),
    .beat     (beat),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
